@@ rtl/mac_ipb_pkg.sv @@
// shared types and constants for the mac/ip binding table
// no dependencies
package mac_ipb_pkg;

  localparam int unsigned TableEntries   = 32;
  localparam int unsigned TicksPerSecond = 100;
  localparam int unsigned SlotW          = $clog2(TableEntries);
  localparam logic [31:0] LifetimeReset  = 32'd600;

  typedef enum logic [1:0] {
    REQ_LEARN   = 2'd0,
    REQ_BY_IP   = 2'd1,
    REQ_BY_MAC  = 2'd2,
    REQ_FLUSH   = 2'd3
  } req_t;

  typedef enum logic [2:0] {
    ST_MISS      = 3'd0,
    ST_HIT       = 3'd1,
    ST_INSERTED  = 3'd2,
    ST_REFRESHED = 3'd3,
    ST_FULL      = 3'd4,
    ST_FLUSHED   = 3'd5
  } status_t;

  // controller to datapath
  typedef struct packed {
    logic capture;   // latch the request
    logic scan_rd;   // issue memory read at scan index
    logic scan_eval; // evaluate read data of previous index
    logic finish;    // apply write and form result
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic scan_last; // last read address issued
  } dp_sts_t;

endpackage

@@ rtl/mac_ipb_datapath.sv @@
// table storage, scan/expiry logic and result register
// depends on mac_ipb_pkg
module mac_ipb_datapath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mac_ipb_pkg::dp_cmd_t       cmd,
  output mac_ipb_pkg::dp_sts_t       sts,
  input  logic [31:0]                lifetime,
  input  logic [1:0]                 req_type,
  input  logic [47:0]                station_mac,
  input  logic [31:0]                station_ip,
  input  logic [31:0]                now_ticks,
  output logic [2:0]                 res_status,
  output logic [47:0]                res_mac,
  output logic [31:0]                res_ip
);

  localparam int unsigned SW = mac_ipb_pkg::SlotW;
  localparam int unsigned N  = mac_ipb_pkg::TableEntries;

  // memories
  logic [47:0] mem_mac [N];
  logic [31:0] mem_ip  [N];
  logic [31:0] mem_exp [N];
  logic [31:0] mem_ord [N];
  logic [N-1:0] valid_r, valid_nxt;

  logic [1:0]  req_r;
  logic [47:0] mac_r;
  logic [31:0] ip_r, now_r, expiry_r, ctr_r, ctr_nxt;

  logic [SW-1:0] rd_idx_r, ev_idx_r;
  logic [47:0] rd_mac_r;
  logic [31:0] rd_ip_r, rd_exp_r, rd_ord_r;

  logic          best_v_r, free_v_r;
  logic [SW-1:0] best_idx_r, free_idx_r;
  logic [31:0]   best_age_r;
  logic [47:0]   best_mac_r;
  logic [31:0]   best_ip_r;

  logic [2:0]  st_r;
  logic [47:0] omac_r;
  logic [31:0] oip_r;

  logic [31:0] prod;
  assign prod = lifetime * 32'(mac_ipb_pkg::TicksPerSecond);

  assign sts.scan_last = (rd_idx_r == SW'(N - 1));

  // memory read port
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      rd_mac_r <= mem_mac[rd_idx_r];
      rd_ip_r  <= mem_ip[rd_idx_r];
      rd_exp_r <= mem_exp[rd_idx_r];
      rd_ord_r <= mem_ord[rd_idx_r];
      ev_idx_r <= rd_idx_r;
    end
  end

  logic        ev_live, ev_match;
  logic [31:0] ev_age;
  always_comb begin
    ev_live  = valid_r[ev_idx_r] && !(rd_exp_r < now_r);
    ev_match = ev_live && ((req_r == mac_ipb_pkg::REQ_BY_IP) ? (rd_ip_r == ip_r)
                                                           : (rd_mac_r == mac_r));
    ev_age   = ctr_r - rd_ord_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r    <= req_type;
      mac_r    <= station_mac;
      ip_r     <= station_ip;
      now_r    <= now_ticks;
      expiry_r <= now_ticks + prod;
      rd_idx_r <= '0;
      best_v_r <= 1'b0;
      free_v_r <= 1'b0;
    end else begin
      if (cmd.scan_rd && !sts.scan_last) rd_idx_r <= rd_idx_r + SW'(1);
      if (cmd.scan_eval) begin
        if (ev_match && (!best_v_r || ev_age < best_age_r)) begin
          best_v_r   <= 1'b1;
          best_idx_r <= ev_idx_r;
          best_age_r <= ev_age;
          best_mac_r <= rd_mac_r;
          best_ip_r  <= rd_ip_r;
        end
        if (!ev_live && !free_v_r) begin
          free_v_r   <= 1'b1;
          free_idx_r <= ev_idx_r;
        end
      end
    end
  end

  // valid bits: expiry clears during scan, finish applies request
  always_comb begin
    valid_nxt = valid_r;
    ctr_nxt   = ctr_r;
    if (cmd.scan_eval && !ev_live) valid_nxt[ev_idx_r] = 1'b0;
    if (cmd.finish) begin
      if (req_r == mac_ipb_pkg::REQ_FLUSH) valid_nxt = '0;
      else if (req_r == mac_ipb_pkg::REQ_LEARN && !best_v_r && free_v_r) begin
        valid_nxt[free_idx_r] = 1'b1;
        ctr_nxt = ctr_r + 32'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ctr_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      ctr_r   <= ctr_nxt;
    end
  end

  // memory write port
  logic          wr_en, wr_new;
  logic [SW-1:0] wr_idx;
  always_comb begin
    wr_en  = cmd.finish && req_r == mac_ipb_pkg::REQ_LEARN && (best_v_r || free_v_r);
    wr_new = !best_v_r;
    wr_idx = best_v_r ? best_idx_r : free_idx_r;
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_ip[wr_idx]  <= ip_r;
      mem_exp[wr_idx] <= expiry_r;
      if (wr_new) begin
        mem_mac[wr_idx] <= mac_r;
        mem_ord[wr_idx] <= ctr_r;
      end
    end
  end

  // result
  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      omac_r <= '0;
      oip_r  <= '0;
      unique case (req_r)
        mac_ipb_pkg::REQ_LEARN:
          st_r <= best_v_r ? mac_ipb_pkg::ST_REFRESHED :
                  free_v_r ? mac_ipb_pkg::ST_INSERTED : mac_ipb_pkg::ST_FULL;
        mac_ipb_pkg::REQ_BY_IP: begin
          st_r <= best_v_r ? mac_ipb_pkg::ST_HIT : mac_ipb_pkg::ST_MISS;
          if (best_v_r) omac_r <= best_mac_r;
        end
        mac_ipb_pkg::REQ_BY_MAC: begin
          st_r <= best_v_r ? mac_ipb_pkg::ST_HIT : mac_ipb_pkg::ST_MISS;
          if (best_v_r) oip_r <= best_ip_r;
        end
        default: st_r <= mac_ipb_pkg::ST_FLUSHED;
      endcase
    end
  end

  assign res_status = st_r;
  assign res_mac    = omac_r;
  assign res_ip     = oip_r;

endmodule

@@ rtl/mac_ipb_ctrl.sv @@
// sequencing state machine for one request
// depends on mac_ipb_pkg
module mac_ipb_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  output logic                 out_valid,
  input  logic                 out_ready,
  output mac_ipb_pkg::dp_cmd_t cmd,
  input  mac_ipb_pkg::dp_sts_t sts
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_TAIL = 5'b00100,
    S_FIN  = 5'b01000,
    S_OUT  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_SCAN;
          first_nxt   = 1'b1;
        end
      end
      S_SCAN: begin
        cmd.scan_rd   = 1'b1;
        cmd.scan_eval = !first_r;
        first_nxt     = 1'b0;
        if (sts.scan_last) state_nxt = S_TAIL;
      end
      S_TAIL: begin
        cmd.scan_eval = 1'b1;
        state_nxt     = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt  = S_OUT;
      end
      S_OUT: begin
        out_valid = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
    end
  end

endmodule

@@ rtl/mac_ip_binding_table_aging_top.sv @@
// top level of the mac/ip binding table with aging
// depends on mac_ipb_pkg, mac_ipb_ctrl, mac_ipb_datapath
//
// usage
//   in_ channel: one request per handshake (in_valid/in_ready), carrying the
//   request type, mac, ip and the current tick count
//   out_ channel: exactly one result per request (out_valid/out_ready)
//   cfg_ port: user writes lifetime in seconds only while idle; unenforced
// scan and throughput
//   a request is served by a scan over all TableEntries slots through the
//   single read port of the slot memory, which the scan walks one slot per
//   cycle for match and expiry
//   one request is handled at a time; in_ready is high only when idle
// reset
//   synchronous active-low rst_n clears the valid bits, the insert
//   counter and the sequencer, and sets the lifetime to 600 seconds
// stall
//   while out_ready is low the result holds on the out_ ports and no new
//   request is taken
module mac_ip_binding_table_aging_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_req_type,
  input  logic [47:0] in_station_mac,
  input  logic [31:0] in_station_ip,
  input  logic [31:0] in_now_ticks,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  out_status,
  output logic [47:0] out_found_mac,
  output logic [31:0] out_found_ip,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  mac_ipb_pkg::dp_cmd_t cmd;
  mac_ipb_pkg::dp_sts_t sts;
  logic [31:0] lifetime_r;

  // lifetime register
  always_ff @(posedge clk) begin
    if (!rst_n) lifetime_r <= mac_ipb_pkg::LifetimeReset;
    else if (cfg_we) lifetime_r <= cfg_wdata;
  end

  // sequencer
  mac_ipb_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .sts       (sts)
  );

  // table and result datapath
  mac_ipb_datapath u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .lifetime    (lifetime_r),
    .req_type    (in_req_type),
    .station_mac (in_station_mac),
    .station_ip  (in_station_ip),
    .now_ticks   (in_now_ticks),
    .res_status  (out_status),
    .res_mac     (out_found_mac),
    .res_ip      (out_found_ip)
  );

endmodule

@@ rtl/mac_ipb_checker.sv @@
// port-level checks for the binding table
// depends on mac_ip_binding_table_aging_top
module mac_ipb_port_props (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  out_status,
  input logic [47:0] out_found_mac,
  input logic [31:0] out_found_ip
);

  // one request at a time
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("ready while result pending");

  // result status held while stalled
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status))
    else $error("result dropped under stall");

  // found fields zero unless a hit
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != mac_ipb_pkg::ST_HIT |->
      out_found_mac == '0 && out_found_ip == '0) else $error("stray found data");

  // accept leads to busy
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready) else $error("accepted twice");

endmodule

bind mac_ip_binding_table_aging_top mac_ipb_port_props u_chk (.*);
